// ----- design/tnefad_pkg.sv -----
package tnefad_pkg;

  localparam logic [31:0] STREAM_MAGIC   = 32'h223E_9F78;
  localparam logic [7:0]  LEVEL_MESSAGE  = 8'h01;
  localparam logic [7:0]  LEVEL_ATTACH   = 8'h02;
  localparam logic [15:0] TAG_BODY       = 16'h800C;
  localparam logic [15:0] TAG_DATA       = 16'h800F;
  localparam logic [15:0] TAG_TITLE      = 16'h8010;
  localparam logic [7:0]  BYTE_LF        = 8'h0A;
  localparam logic [7:0]  BYTE_CR        = 8'h0D;
  localparam logic [31:0] MIN_STREAM_LEN = 32'd6;
  localparam logic [31:0] CFG_LEN_RESET  = 32'd6;

  // result kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TITLE  = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_OBJECT = 2'd3;

  // finish status codes
  localparam logic [1:0] STAT_CLEAN      = 2'd0;
  localparam logic [1:0] STAT_INCOMPLETE = 2'd1;
  localparam logic [1:0] STAT_FORMAT     = 2'd2;

  typedef enum logic [3:0] {
    PH_SIG     = 4'd0,
    PH_LVLWORD = 4'd1,
    PH_LEVEL   = 4'd2,
    PH_TAG     = 4'd3,
    PH_LEN     = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CHECK   = 4'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       fin;
    logic [1:0] status;
  } tnefad_res_t;

endpackage

// ----- design/tnefad_in_if.sv -----
interface tnefad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- design/tnefad_out_if.sv -----
interface tnefad_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       first_in_attribute;
  logic       finished;
  logic [1:0] status;

  modport source (output valid, output kind, output out_byte, output first_in_attribute,
                  output finished, output status, input ready);
  modport sink   (input valid, input kind, input out_byte, input first_in_attribute,
                  input finished, input status, output ready);
endinterface

// ----- design/tnefad_parser.sv -----
module tnefad_parser
  import tnefad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic [31:0] stream_len,
  output tnefad_res_t res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] position_r, position_nxt;
  logic [31:0] word_r, word_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [31:0] payload_r, payload_nxt;
  logic        body_r, body_nxt;
  logic        done_r, done_nxt;

  logic [1:0]  kind;
  logic [7:0]  obyte;
  logic        first;
  logic        fin;
  logic [1:0]  stat;

  logic [31:0] pos_inc;
  logic [31:0] shifted;
  logic [32:0] end_pos;
  logic        rem_small;

  assign pos_inc  = position_r + 32'd1;
  assign shifted  = {24'd0, in_byte} << {cnt_r[1:0], 3'b000};
  assign end_pos  = {1'b0, pos_inc} + {1'b0, word_r | shifted};
  // bytes left after this one is fewer than four (or already past the end)
  assign rem_small = (pos_inc > stream_len) || ((stream_len - pos_inc) < 32'd4);

  // next state, result fields and finish flags
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    position_nxt = position_r;
    word_nxt     = word_r;
    level_nxt    = level_r;
    tag_nxt      = tag_r;
    payload_nxt  = payload_r;
    body_nxt     = body_r;
    kind         = KIND_NONE;
    obyte        = 8'd0;
    first        = 1'b0;
    fin          = 1'b0;
    stat         = STAT_CLEAN;

    if (!done_r) begin
      if (phase_r == PH_SIG && stream_len < MIN_STREAM_LEN) begin
        fin  = 1'b1;
        stat = STAT_INCOMPLETE;
      end else begin
        position_nxt = pos_inc;
        case (phase_r)
          PH_SIG: begin
            word_nxt = word_r | shifted;
            cnt_nxt  = cnt_r + 3'd1;
            if (cnt_r >= 3'd3) begin
              cnt_nxt = 3'd0;
              if (word_nxt != STREAM_MAGIC) begin
                fin  = 1'b1;
                stat = STAT_FORMAT;
              end else begin
                phase_nxt = PH_LVLWORD;
              end
            end
          end
          PH_LVLWORD, PH_CHECK: begin
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_r >= 3'd1) begin
              cnt_nxt   = 3'd0;
              phase_nxt = PH_LEVEL;
            end
          end
          PH_TAG, PH_LEN: begin
            word_nxt = word_r | shifted;
            cnt_nxt  = cnt_r + 3'd1;
            if (cnt_r >= 3'd3) begin
              cnt_nxt = 3'd0;
              if (phase_r == PH_TAG) begin
                tag_nxt   = word_nxt[15:0];
                word_nxt  = 32'd0;
                phase_nxt = PH_LEN;
              end else if (word_nxt == 32'd0) begin
                // empty attribute: no checksum follows
                phase_nxt = PH_LEVEL;
              end else if (word_nxt[31]) begin
                fin  = 1'b1;
                stat = STAT_FORMAT;
              end else begin
                if (level_r == LEVEL_MESSAGE) begin
                  if (tag_r == TAG_BODY) body_nxt = 1'b1;
                  kind = KIND_OBJECT;
                end
                if (level_r != LEVEL_MESSAGE && level_r != LEVEL_ATTACH) begin
                  fin  = 1'b1;
                  stat = STAT_FORMAT;
                end else if (end_pos > {1'b0, stream_len}) begin
                  fin  = 1'b1;
                  stat = STAT_FORMAT;
                end else begin
                  payload_nxt = word_nxt;
                  phase_nxt   = PH_PAYLOAD;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            if (level_r == LEVEL_ATTACH && (tag_r == TAG_TITLE || tag_r == TAG_DATA)) begin
              kind  = (tag_r == TAG_TITLE) ? KIND_TITLE : KIND_DATA;
              obyte = in_byte;
              // word_r still holds the attribute length
              first = (payload_r == word_r);
            end
            payload_nxt = payload_r - 32'd1;
            if (payload_r == 32'd1) begin
              cnt_nxt   = 3'd0;
              phase_nxt = PH_CHECK;
            end
          end
          default: begin
            // level byte of the next attribute
            level_nxt = in_byte;
            if (in_byte == 8'd0 ||
                ((in_byte == BYTE_LF || in_byte == BYTE_CR) && rem_small)) begin
              fin  = 1'b1;
              stat = body_r ? STAT_INCOMPLETE : STAT_CLEAN;
            end else begin
              phase_nxt = PH_TAG;
              cnt_nxt   = 3'd0;
              word_nxt  = 32'd0;
            end
          end
        endcase

        if (!fin && pos_inc >= stream_len) begin
          fin  = 1'b1;
          stat = (phase_nxt == PH_LEVEL && !body_nxt) ? STAT_CLEAN : STAT_INCOMPLETE;
        end
      end
    end

    done_nxt = done_r | fin;
  end

  // result assembly
  always_comb begin
    res.kind   = kind;
    res.data   = obyte;
    res.first  = first;
    res.fin    = fin;
    res.status = stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIG;
      cnt_r      <= 3'd0;
      position_r <= 32'd0;
      word_r     <= 32'd0;
      level_r    <= 8'd0;
      tag_r      <= 16'd0;
      payload_r  <= 32'd0;
      body_r     <= 1'b0;
      done_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      position_r <= position_nxt;
      word_r     <= word_nxt;
      level_r    <= level_nxt;
      tag_r      <= tag_nxt;
      payload_r  <= payload_nxt;
      body_r     <= body_nxt;
      done_r     <= done_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    step && done_r |-> (res.kind == KIND_NONE && !res.fin))
    else $error("tnefad_parser: activity after finish");

  assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_PAYLOAD |-> payload_r != 32'd0)
    else $error("tnefad_parser: payload phase with no bytes left");

  assert property (@(posedge clk) disable iff (!rst_n)
    step && res.fin |=> done_r)
    else $error("tnefad_parser: finish not latched");

endmodule

// ----- design/tnef_attribute_deframer_unit.sv -----
// channel  | dir | payload                                            | handshake
// in_ch    | in  | in_byte[7:0]                                       | valid/ready
// out_ch   | out | kind, out_byte, first_in_attribute, finished,     | valid/ready
//          |     | status                                             |
// cfg_*    | in  | cfg_wr_data[31:0] = stream_length                  | cfg_wr_en
//
// One result per stream byte; the result is registered and appears in the cycle after the
// byte is taken. Sustained rate is one byte per clock while out_ch.ready stays high: the
// parser state steps on each accepted byte and the result register is refilled in the same cycle it is drained.
// Reset (synchronous, rst_n low) returns to the signature phase, stream_length = 6.
// A stalled result holds in_ch.ready low until out_ch.ready takes it.
module tnef_attribute_deframer_unit
  import tnefad_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tnefad_in_if.sink         in_ch,
  tnefad_out_if.source      out_ch,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  logic [31:0] stream_len_r;
  logic        out_valid_r;
  tnefad_res_t res;
  tnefad_res_t res_r;
  logic        step;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  tnefad_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .in_byte    (in_ch.in_byte),
    .stream_len (stream_len_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_len_r <= CFG_LEN_RESET;
    end else if (cfg_wr_en) begin
      stream_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.kind               = res_r.kind;
  assign out_ch.out_byte           = res_r.data;
  assign out_ch.first_in_attribute = res_r.first;
  assign out_ch.finished           = res_r.fin;
  assign out_ch.status             = res_r.status;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.finished |=> !(out_ch.valid && out_ch.finished))
    else $error("deframer: second finish request");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.first_in_attribute |->
      (out_ch.kind == KIND_TITLE || out_ch.kind == KIND_DATA))
    else $error("deframer: first flag on non-payload result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.finished |-> out_ch.status == STAT_CLEAN)
    else $error("deframer: status without finish");

  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r)
    else $error("deframer: input stalled with empty result register");

endmodule
